// ===== sv/kocc_pkg.sv =====
// Shared types, codes and architecture limits for the kernel occupancy calculator.
// Depends on nothing; imported by every module of the block but kocc_div.
package kocc_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_REGS = 2'd1;
    localparam logic [1:0] ST_BAD_ARCH = 2'd2;
    localparam logic [1:0] ST_NOT_CFG  = 2'd3;

    // Configuration register indexes
    localparam logic REG_ARCH_CODE = 1'b0;
    localparam logic REG_THREADS   = 1'b1;

    // Cache split codes; anything above equal means prefer L1
    localparam logic [1:0] CACHE_SHARED = 2'd0;
    localparam logic [1:0] CACHE_EQUAL  = 2'd1;

    localparam int CFG_DW   = 11;
    localparam int DEN_W    = 24;
    localparam int USED_W   = 19;
    localparam int SPARE_QB = 21;

    localparam logic [19:0] SPARE_MAX = 20'hFFFFF;
    localparam logic [16:0] FRAC_MAX  = 17'h1FFFF;

    // Limits of one architecture, in the form the datapath uses
    typedef struct packed {
        logic        known;
        logic        mw48;       // 48 warps per SM, else 64
        logic [5:0]  max_blocks;
        logic [9:0]  reg_cu;     // register block size in allocation units
        logic        ratio2;     // register file holds two register blocks
        logic        small_units;// 64-register and 128-byte allocation units
        logic        gran4;      // warp allocation granularity 4, else 2
        logic [7:0]  reg_tmax;
        logic [16:0] cap0;
        logic [16:0] cap1;
        logic [16:0] cap2;
    } arch_lim_t;

    // Sideband carried alongside the spare-memory division
    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        blocks;
        logic [6:0]        active;
        logic              mw48;
        logic [USED_W-1:0] used;
    } side_t;

    function automatic arch_lim_t arch_lookup(input logic [6:0] code);
        arch_lim_t l;
        l = '0;
        l.known       = 1'b1;
        l.mw48        = 1'b0;
        l.max_blocks  = 6'd32;
        l.reg_cu      = 10'd256;
        l.ratio2      = 1'b0;
        l.small_units = 1'b0;
        l.gran4       = 1'b1;
        l.reg_tmax    = 8'd255;
        l.cap0        = 17'd65536;
        l.cap1        = 17'd65536;
        l.cap2        = 17'd65536;
        unique case (code) inside
            7'd20, 7'd21:
            begin
                l.mw48        = 1'b1;
                l.max_blocks  = 6'd8;
                l.reg_cu      = 10'd512;
                l.small_units = 1'b1;
                l.gran4       = 1'b0;
                l.reg_tmax    = 8'd63;
                l.cap0        = 17'd49152;
                l.cap1        = 17'd16384;
                l.cap2        = 17'd16384;
            end
            7'd30:
            begin
                l.max_blocks = 6'd16;
                l.reg_tmax   = 8'd63;
                l.cap0       = 17'd49152;
                l.cap1       = 17'd32768;
                l.cap2       = 17'd16384;
            end
            7'd32, 7'd35:
            begin
                l.max_blocks = 6'd16;
                l.cap0       = 17'd49152;
                l.cap1       = 17'd32768;
                l.cap2       = 17'd16384;
            end
            7'd37:
            begin
                l.max_blocks = 6'd16;
                l.ratio2     = 1'b1;
                l.cap0       = 17'd114688;
                l.cap1       = 17'd98304;
                l.cap2       = 17'd81920;
            end
            7'd50, 7'd60, 7'd61:
            begin
                l.known = 1'b1;
            end
            7'd52:
            begin
                l.cap0 = 17'd98304;
                l.cap1 = 17'd98304;
                l.cap2 = 17'd98304;
            end
            7'd53:
            begin
                l.reg_cu = 10'd128;
                l.ratio2 = 1'b1;
            end
            default:
            begin
                l.known = 1'b0;
            end
        endcase
        return l;
    endfunction

endpackage

// ===== sv/kocc_front.sv =====
// Front pipeline: request decode and the warp, register and shared-memory limits.
// Depends on kocc_pkg; feeds the spare-memory divider with its operands and sideband.
module kocc_front
    import kocc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int NW        = 39
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [7:0]        regs_per_thread,
    input  logic [17:0]       smem_bytes,
    input  logic [1:0]        cache_mode,
    input  logic [16:0]       target_occupancy,
    input  logic [6:0]        arch_code,
    input  logic [10:0]       threads_per_block,
    output logic              out_valid,
    output logic [NW-1:0]     out_n,
    output logic [DEN_W-1:0]  out_d,
    output side_t             out_side
);

    // Stage 1 signals
    arch_lim_t         lim_c;
    logic [1:0]        status_c;
    logic [6:0]        wpb_c;
    logic [12:0]       rsum_c;
    logic [7:0]        u_c;
    logic [18:0]       sm_c;
    logic [USED_W-1:0] used_c;
    logic [16:0]       cap_c;
    logic [NW-1:0]     n_c;
    logic [DEN_W-1:0]  d_c;

    logic              v1_reg;
    arch_lim_t         lim1_reg;
    logic [1:0]        st1_reg;
    logic [6:0]        wpb1_reg;
    logic [7:0]        u1_reg;
    logic [USED_W-1:0] used1_reg;
    logic [16:0]       cap1_reg;
    logic [NW-1:0]     n1_reg;
    logic [DEN_W-1:0]  d1_reg;

    // Stage 2 signals
    logic [31:0]       warp_ok_c;
    logic [31:0]       smem_ok_c;
    logic [10:0]       m_c [32];

    logic              v2_reg;
    arch_lim_t         lim2_reg;
    logic [1:0]        st2_reg;
    logic [6:0]        wpb2_reg;
    logic [7:0]        u2_reg;
    logic [USED_W-1:0] used2_reg;
    logic [NW-1:0]     n2_reg;
    logic [DEN_W-1:0]  d2_reg;
    logic [31:0]       warp_ok2_reg;
    logic [31:0]       smem_ok2_reg;
    logic [10:0]       m2_reg [32];

    // Stage 3 signals
    logic [31:0]       reg_ok_c;
    logic [31:0]       ok_c;

    logic              v3_reg;
    logic              mw48_3_reg;
    logic [1:0]        st3_reg;
    logic [6:0]        wpb3_reg;
    logic [USED_W-1:0] used3_reg;
    logic [NW-1:0]     n3_reg;
    logic [DEN_W-1:0]  d3_reg;
    logic [31:0]       ok3_reg;

    // Stage 4 signals
    logic [32:0]       okx_c;
    logic [5:0]        blocks_c;
    logic [6:0]        active_c;

    logic              v4_reg;
    side_t             side4_reg;
    logic [NW-1:0]     n4_reg;
    logic [DEN_W-1:0]  d4_reg;

    // Decode the request against the selected limits table
    always_comb
    begin
        lim_c = arch_lookup(arch_code);
        if (arch_code == '0 || threads_per_block == '0)
            status_c = ST_NOT_CFG;
        else if (!lim_c.known)
            status_c = ST_BAD_ARCH;
        else if (regs_per_thread == '0 || regs_per_thread > lim_c.reg_tmax)
            status_c = ST_BAD_REGS;
        else
            status_c = ST_OK;

        wpb_c  = 7'((12'(threads_per_block) + 12'd31) >> 5);
        rsum_c = {regs_per_thread, 5'b0};
        if (lim_c.small_units)
        begin
            sm_c   = 19'(smem_bytes) + 19'd127;
            used_c = {sm_c[18:7], 7'b0};
            u_c    = 8'((14'(rsum_c) + 14'd63) >> 6);
        end
        else
        begin
            sm_c   = 19'(smem_bytes) + 19'd255;
            used_c = {sm_c[18:8], 8'b0};
            u_c    = 8'((14'(rsum_c) + 14'd255) >> 8);
        end

        case (cache_mode)
            CACHE_SHARED: cap_c = lim_c.cap0;
            CACHE_EQUAL:  cap_c = lim_c.cap1;
            default:      cap_c = lim_c.cap2;
        endcase

        n_c = NW'(23'(threads_per_block[10:5]) * 23'(cap_c)) << FRAC_BITS;
        if (lim_c.mw48)
            d_c = (DEN_W'(target_occupancy) << 5) + (DEN_W'(target_occupancy) << 4);
        else
            d_c = DEN_W'(target_occupancy) << 6;
    end

    // Per candidate block count: warp/block limit, shared limit, rounded warp need
    always_comb
    begin
        logic [11:0] kw;
        kw = '0;
        for (int k = 0; k < 32; k++)
        begin
            kw = 12'(k + 1) * 12'(wpb1_reg);
            warp_ok_c[k] = (kw <= (lim1_reg.mw48 ? 12'd48 : 12'd64))
                           && (6'(k + 1) <= lim1_reg.max_blocks);
            smem_ok_c[k] = (used1_reg == '0)
                           || (24'(k + 1) * 24'(used1_reg) <= 24'(cap1_reg));
            m_c[k] = lim1_reg.gran4 ? 11'((kw + 12'd3) >> 2) : 11'((kw + 12'd1) >> 1);
        end
    end

    // Register limit per candidate and the combined fit vector
    always_comb
    begin
        logic [19:0] prod;
        logic [19:0] prod_g;
        logic        rsel;
        prod   = '0;
        prod_g = '0;
        rsel   = 1'b0;
        for (int k = 0; k < 32; k++)
        begin
            prod        = 20'(m2_reg[k]) * 20'(u2_reg);
            prod_g      = lim2_reg.gran4 ? (prod << 2) : (prod << 1);
            reg_ok_c[k] = prod_g <= 20'(lim2_reg.reg_cu);
        end
        for (int k = 0; k < 32; k++)
        begin
            rsel    = lim2_reg.ratio2 ? reg_ok_c[k >> 1] : reg_ok_c[k];
            ok_c[k] = warp_ok2_reg[k] & smem_ok2_reg[k] & rsel;
        end
    end

    // Fit vector is a prefix: the block count sits at its last set bit
    always_comb
    begin
        okx_c    = {1'b0, ok3_reg};
        blocks_c = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (okx_c[k] && !okx_c[k + 1])
                blocks_c = blocks_c | 6'(k + 1);
        end
        active_c = 7'(13'(blocks_c) * 13'(wpb3_reg));
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lim1_reg  <= lim_c;
            st1_reg   <= status_c;
            wpb1_reg  <= wpb_c;
            u1_reg    <= u_c;
            used1_reg <= used_c;
            cap1_reg  <= cap_c;
            n1_reg    <= n_c;
            d1_reg    <= d_c;

            lim2_reg     <= lim1_reg;
            st2_reg      <= st1_reg;
            wpb2_reg     <= wpb1_reg;
            u2_reg       <= u1_reg;
            used2_reg    <= used1_reg;
            n2_reg       <= n1_reg;
            d2_reg       <= d1_reg;
            warp_ok2_reg <= warp_ok_c;
            smem_ok2_reg <= smem_ok_c;
            m2_reg       <= m_c;

            mw48_3_reg <= lim2_reg.mw48;
            st3_reg    <= st2_reg;
            wpb3_reg   <= wpb2_reg;
            used3_reg  <= used2_reg;
            n3_reg     <= n2_reg;
            d3_reg     <= d2_reg;
            ok3_reg    <= ok_c;

            side4_reg.status <= st3_reg;
            side4_reg.blocks <= blocks_c;
            side4_reg.active <= active_c;
            side4_reg.mw48   <= mw48_3_reg;
            side4_reg.used   <= used3_reg;
            n4_reg           <= n3_reg;
            d4_reg           <= d3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_n     = n4_reg;
    assign out_d     = d4_reg;
    assign out_side  = side4_reg;

endmodule

// ===== sv/kocc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// Depends on nothing; carries an opaque sideband word alongside each operand pair.
module kocc_div #(
    parameter int NW = 39,
    parameter int DW = 24,
    parameter int QB = 21,
    parameter int SW = 35
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] in_n,
    input  logic [DW-1:0] in_d,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] out_quot,
    output logic          out_ovf,
    output logic [SW-1:0] out_side
);

    localparam int CW = (NW > DW + QB) ? NW + 1 : DW + QB + 1;

    logic          v_reg   [QB];
    logic [NW-1:0] r_reg   [QB];
    logic [QB-1:0] q_reg   [QB];
    logic [DW-1:0] d_reg   [QB];
    logic          ovf_reg [QB];
    logic [SW-1:0] s_reg   [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic          v_in;
        logic [NW-1:0] r_in;
        logic [QB-1:0] q_in;
        logic [DW-1:0] d_in;
        logic          ovf_in;
        logic [SW-1:0] s_in;
        logic [CW-1:0] dsh;
        logic          ge;

        if (j == 0)
        begin : g_first
            // Quotient wider than QB bits sets the overflow flag
            assign v_in   = in_valid;
            assign r_in   = in_n;
            assign q_in   = '0;
            assign d_in   = in_d;
            assign ovf_in = CW'(in_n) >= (CW'(in_d) << QB);
            assign s_in   = in_side;
        end
        else
        begin : g_next
            assign v_in   = v_reg[j - 1];
            assign r_in   = r_reg[j - 1];
            assign q_in   = q_reg[j - 1];
            assign d_in   = d_reg[j - 1];
            assign ovf_in = ovf_reg[j - 1];
            assign s_in   = s_reg[j - 1];
        end

        // Trial subtract of the shifted divisor
        assign dsh = CW'(d_in) << (QB - 1 - j);
        assign ge  = CW'(r_in) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (adv)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[j]   <= ge ? NW'(CW'(r_in) - dsh) : r_in;
                q_reg[j]   <= ge ? (q_in | (QB'(1) << (QB - 1 - j))) : q_in;
                d_reg[j]   <= d_in;
                ovf_reg[j] <= ovf_in;
                s_reg[j]   <= s_in;
            end
        end
    end

    assign out_valid = v_reg[QB - 1];
    assign out_quot  = q_reg[QB - 1];
    assign out_ovf   = ovf_reg[QB - 1];
    assign out_side  = s_reg[QB - 1];

endmodule

// ===== sv/kernel_occupancy_calc_top.sv =====
// Kernel occupancy calculator, top level.
// One transaction per cycle while no waiting result under out_stall holds the pipeline.
// The spare-memory division sets the depth: 21 restoring stages, one quotient bit each,
// behind four limit stages and followed by one output register.
// A single advance enable moves the whole pipeline; in_stall follows out_valid and out_stall.
// rst_n clears the configuration to not configured and empties the pipeline at once.
module kernel_occupancy_calc_top
    import kocc_pkg::*;
#(
    parameter int OCC_FRAC_BITS = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        regs_per_thread,
    input  logic [17:0]       smem_bytes,
    input  logic [1:0]        cache_mode,
    input  logic [16:0]       target_occupancy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [5:0]        blocks_per_sm,
    output logic [6:0]        active_warps,
    output logic [16:0]       occupancy_frac,
    output logic [19:0]       spare_smem_bytes
);

    localparam int NW = 23 + OCC_FRAC_BITS;
    localparam int FW = 24 + OCC_FRAC_BITS;
    localparam int SW = $bits(side_t);
    localparam int R1 = (1 << (OCC_FRAC_BITS - 4)) / 3;
    localparam int R2 = (1 << (OCC_FRAC_BITS - 3)) / 3;

    logic [6:0]  arch_code_reg;
    logic [10:0] threads_reg;
    logic        adv;

    logic              fr_valid;
    logic [NW-1:0]     fr_n;
    logic [DEN_W-1:0]  fr_d;
    side_t             fr_side;

    logic                div_valid;
    logic [SPARE_QB-1:0] div_quot;
    logic                div_ovf;
    logic [SW-1:0]       div_side;

    side_t               side_c;
    logic [6:0]          q3_c;
    logic [1:0]          r3_c;
    logic [FW-1:0]       rterm_c;
    logic [FW-1:0]       frac_w_c;
    logic [16:0]         frac_c;
    logic [SPARE_QB-1:0] diff_c;
    logic [19:0]         spare_c;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [5:0]  blocks_reg;
    logic [6:0]  active_reg;
    logic [16:0] frac_reg;
    logic [19:0] spare_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_code_reg <= '0;
            threads_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ARCH_CODE: arch_code_reg <= cfg_data[6:0];
                REG_THREADS:   threads_reg   <= cfg_data;
            endcase
        end
    end

    // Hold the whole pipeline while the output transaction waits
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    kocc_front #(
        .FRAC_BITS (OCC_FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (in_valid),
        .regs_per_thread   (regs_per_thread),
        .smem_bytes        (smem_bytes),
        .cache_mode        (cache_mode),
        .target_occupancy  (target_occupancy),
        .arch_code         (arch_code_reg),
        .threads_per_block (threads_reg),
        .out_valid         (fr_valid),
        .out_n             (fr_n),
        .out_d             (fr_d),
        .out_side          (fr_side)
    );

    kocc_div #(
        .NW (NW),
        .DW (DEN_W),
        .QB (SPARE_QB),
        .SW (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_n      (fr_n),
        .in_d      (fr_d),
        .in_side   (SW'(fr_side)),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_ovf   (div_ovf),
        .out_side  (div_side)
    );

    // Occupancy fraction: a shift for 64 warps, a split divide by three for 48
    always_comb
    begin
        side_c = side_t'(div_side);
        q3_c   = 7'((15'(side_c.active) * 15'd171) >> 9);
        r3_c   = 2'(side_c.active - (q3_c << 1) - q3_c);
        case (r3_c)
            2'd1:    rterm_c = FW'(R1);
            2'd2:    rterm_c = FW'(R2);
            default: rterm_c = '0;
        endcase
        if (side_c.mw48)
            frac_w_c = (FW'(q3_c) << (OCC_FRAC_BITS - 4)) + rterm_c;
        else
            frac_w_c = FW'(side_c.active) << (OCC_FRAC_BITS - 6);
        frac_c = (frac_w_c > FW'(FRAC_MAX)) ? FRAC_MAX : 17'(frac_w_c);
    end

    // Spare shared memory: quotient less the rounded use, clamped both ways
    always_comb
    begin
        diff_c = div_quot - SPARE_QB'(side_c.used);
        if (div_ovf)
            spare_c = SPARE_MAX;
        else if (SPARE_QB'(side_c.used) > div_quot)
            spare_c = '0;
        else if (diff_c > SPARE_QB'(SPARE_MAX))
            spare_c = SPARE_MAX;
        else
            spare_c = 20'(diff_c);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= side_c.status;
            if (side_c.status == ST_OK)
            begin
                blocks_reg <= side_c.blocks;
                active_reg <= side_c.active;
                frac_reg   <= frac_c;
                spare_reg  <= spare_c;
            end
            else
            begin
                blocks_reg <= '0;
                active_reg <= '0;
                frac_reg   <= '0;
                spare_reg  <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign blocks_per_sm    = blocks_reg;
    assign active_warps     = active_reg;
    assign occupancy_frac   = frac_reg;
    assign spare_smem_bytes = spare_reg;

endmodule

// ===== sv/kocc_chk.sv =====
// Port-level checker for the kernel occupancy calculator, bound to the top level.
// Depends on kocc_pkg for the status codes.
module kocc_chk
    import kocc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [5:0]  blocks_per_sm,
    input logic [6:0]  active_warps,
    input logic [16:0] occupancy_frac,
    input logic [19:0] spare_smem_bytes
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(blocks_per_sm)
        && $stable(active_warps) && $stable(occupancy_frac) && $stable(spare_smem_bytes))
        else $error("stalled result changed");

    // The input side stalls exactly when a finished result waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output backpressure");

    // Any error status zeroes the result fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> blocks_per_sm == '0 && active_warps == '0
        && occupancy_frac == '0 && spare_smem_bytes == '0)
        else $error("error result carries nonzero fields");

    // Resident blocks and warps stay inside the hardware limits
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> blocks_per_sm <= 6'd32 && active_warps <= 7'd64
        && (blocks_per_sm != '0 || (active_warps == '0 && occupancy_frac == '0)))
        else $error("occupancy result out of range");

endmodule

bind kernel_occupancy_calc_top kocc_chk u_kocc_chk (.*);

// ===== sim/kernel_occupancy_calc_top_test.sv =====
// Testbench for the kernel occupancy calculator: directed and random requests under random gaps.
// Needs kocc_pkg and kernel_occupancy_calc_top; checks each result against its own predictor.
`timescale 1ns / 1ps

module kernel_occupancy_calc_top_test;
    import kocc_pkg::*;

    typedef struct {
        logic [1:0]  st;
        logic [5:0]  blk;
        logic [6:0]  act;
        logic [16:0] frac;
        logic [19:0] spare;
    } occ_result_t;

    // Scoreboard: holds the configuration copy and the queue of predicted results
    class occupancy_scoreboard;
        logic [6:0]  arch;
        logic [10:0] tpb;
        occ_result_t pending[$];
        int          errors;

        function void set_reg(logic idx, logic [10:0] v);
            if (idx == REG_ARCH_CODE)
                arch = v[6:0];
            else
                tpb = v;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        // Work out the occupancy figures for one request
        function occ_result_t occupancy(logic [7:0] regs, logic [17:0] smem,
                                        logic [1:0] cache, logic [16:0] target);
            occ_result_t r;
            longint unsigned mw, mb, rfile, rblock, runit, rtmax, sunit, gran;
            longint unsigned cap0, cap1, cap2, cap;
            longint unsigned wpb, blocks, t, ru, rw, rb, used, sblk, act, frac, lim, spare;
            bit known;
            r = '{ST_OK, 0, 0, 0, 0};
            if (arch == 0 || tpb == 0)
            begin
                r.st = ST_NOT_CFG;
                return r;
            end
            known = 1; mw = 64; mb = 32; rfile = 65536; rblock = 65536; runit = 256;
            rtmax = 255; sunit = 256; gran = 4; cap0 = 65536; cap1 = 65536; cap2 = 65536;
            case (arch)
                20, 21:
                begin
                    mw = 48; mb = 8; rfile = 32768; rblock = 32768; runit = 64; rtmax = 63;
                    sunit = 128; gran = 2; cap0 = 49152; cap1 = 16384; cap2 = 16384;
                end
                30:
                begin
                    mb = 16; rtmax = 63; cap0 = 49152; cap1 = 32768; cap2 = 16384;
                end
                32, 35:
                begin
                    mb = 16; cap0 = 49152; cap1 = 32768; cap2 = 16384;
                end
                37:
                begin
                    mb = 16; rfile = 131072; cap0 = 114688; cap1 = 98304; cap2 = 81920;
                end
                50, 60, 61: known = 1;
                52:
                begin
                    cap0 = 98304; cap1 = 98304; cap2 = 98304;
                end
                53: rblock = 32768;
                default: known = 0;
            endcase
            if (!known)
            begin
                r.st = ST_BAD_ARCH;
                return r;
            end
            if (regs == 0 || regs > rtmax)
            begin
                r.st = ST_BAD_REGS;
                return r;
            end
            cap = (cache == CACHE_SHARED) ? cap0 : (cache == CACHE_EQUAL) ? cap1 : cap2;
            // warp and block limit
            wpb = (tpb + 31) / 32;
            blocks = mw / wpb;
            if (blocks > mb) blocks = mb;
            // register limit
            t = 32 * regs;
            ru = (t % runit == 0) ? t : t - t % runit + runit;
            rw = rblock / ru;
            rw -= rw % gran;
            rb = (rw / wpb) * (rfile / rblock);
            // shared memory limit
            used = (smem % sunit == 0) ? smem : smem - smem % sunit + sunit;
            sblk = (used == 0) ? blocks : cap / used;
            if (blocks > rb) blocks = rb;
            if (blocks > sblk) blocks = sblk;
            act = blocks * wpb;
            frac = (act << 16) / mw;
            if (frac > 64'h1FFFF) frac = 64'h1FFFF;
            // spare shared memory at the target
            if (target == 0)
                spare = 20'hFFFFF;
            else
            begin
                lim = (((tpb / 32) * cap) << 16) / (target * mw);
                spare = (used > lim) ? 0 : lim - used;
                if (spare > 20'hFFFFF) spare = 20'hFFFFF;
            end
            r.blk = blocks[5:0];
            r.act = act[6:0];
            r.frac = frac[16:0];
            r.spare = spare[19:0];
            return r;
        endfunction

        function void note_request(logic [7:0] regs, logic [17:0] smem,
                                   logic [1:0] cache, logic [16:0] target);
            pending.push_back(occupancy(regs, smem, cache, target));
        endfunction

        function void check_result(occ_result_t got);
            occ_result_t e;
            if (pending.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.st !== e.st)
                report($sformatf("status %0d, want %0d", got.st, e.st));
            if (got.blk !== e.blk)
                report($sformatf("blocks_per_sm %0d, want %0d", got.blk, e.blk));
            if (got.act !== e.act)
                report($sformatf("active_warps %0d, want %0d", got.act, e.act));
            if (got.frac !== e.frac)
                report($sformatf("occupancy_frac %0d, want %0d", got.frac, e.frac));
            if (got.spare !== e.spare)
                report($sformatf("spare_smem_bytes %0d, want %0d", got.spare, e.spare));
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_wr_en = 0;
    logic              cfg_index = 0;
    logic [CFG_DW-1:0] cfg_data = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [7:0]        regs_per_thread = 0;
    logic [17:0]       smem_bytes = 0;
    logic [1:0]        cache_mode = 0;
    logic [16:0]       target_occupancy = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [1:0]        status;
    logic [5:0]        blocks_per_sm;
    logic [6:0]        active_warps;
    logic [16:0]       occupancy_frac;
    logic [19:0]       spare_smem_bytes;

    occupancy_scoreboard sb = new;
    bit no_gaps = 0;
    int rx_cycle = 0, hold_left = 0, stall_len = 0, calm_left = 0;

    kernel_occupancy_calc_top dut (.*);

    always #4 clk = ~clk;

    // Monitor accepted requests and results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(regs_per_thread, smem_bytes, cache_mode, target_occupancy);
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, blocks_per_sm, active_warps, occupancy_frac,
                              spare_smem_bytes});
    end

    // Receiver stalls: random stretches, plus one long hold to fill the pipeline
    always @(posedge clk)
    begin
        int r;
        rx_cycle++;
        if (rx_cycle == 3000)
            hold_left = 400;
        if (hold_left > 0)
        begin
            out_stall <= 1;
            hold_left--;
        end
        else if (stall_len > 0)
        begin
            out_stall <= 1;
            stall_len--;
        end
        else if (calm_left > 0)
        begin
            out_stall <= 0;
            calm_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                calm_left = $urandom_range(0, 8);
                out_stall <= 0;
            end
            else if (r < 90)
            begin
                stall_len = $urandom_range(0, 2);
                out_stall <= 1;
            end
            else if (r < 95)
            begin
                stall_len = $urandom_range(10, 40);
                out_stall <= 1;
            end
            else
            begin
                calm_left = $urandom_range(50, 200);
                out_stall <= 0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic [7:0] regs, logic [17:0] smem, logic [1:0] cache,
                             logic [16:0] target);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        regs_per_thread <= regs;
        smem_bytes <= smem;
        cache_mode <= cache;
        target_occupancy <= target;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drain the pipeline before touching the registers
    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [10:0] v);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic set_cfg(logic [10:0] a, logic [10:0] t);
        wait_idle();
        write_cfg(REG_ARCH_CODE, a);
        write_cfg(REG_THREADS, t);
    endtask

    task automatic rand_item();
        logic [7:0]  regs;
        logic [17:0] smem;
        logic [16:0] target;
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) regs = 8'($urandom_range(1, $urandom_range(0, 1) ? 63 : 255));
        else regs = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 15) smem = 0;
        else if (r < 75) smem = 18'($urandom_range(1, 49152));
        else if (r < 90) smem = 18'($urandom_range(0, 131072));
        else smem = 18'($urandom_range(0, 262143));
        r = $urandom_range(0, 99);
        if (r < 5) target = 0;
        else if (r < 85) target = 17'($urandom_range(1, 65536));
        else target = 17'($urandom_range(0, 131071));
        send_item(regs, smem, 2'($urandom_range(0, 3)), target);
    endtask

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int known_codes[11] = '{20, 21, 30, 32, 35, 37, 50, 52, 53, 60, 61};
        int r;
        logic [10:0] a, t;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: unconfigured, unknown architecture, field extremes
        send_item(8'd1, 18'd0, 2'd0, 17'd1);
        set_cfg(11'd20, 11'd0);
        send_item(8'd8, 18'd100, 2'd1, 17'd65536);
        set_cfg(11'd99, 11'd128);
        send_item(8'd8, 18'd100, 2'd1, 17'd65536);
        set_cfg(11'd20, 11'd256);
        send_item(8'd0, 18'd0, 2'd0, 17'd32768);
        send_item(8'd64, 18'd0, 2'd0, 17'd32768);
        send_item(8'd63, 18'd1, 2'd1, 17'd1);
        for (int c = 0; c < 4; c++)
            send_item(8'd1, 18'd4096, c[1:0], 17'd0);
        send_item(8'd20, 18'd262143, 2'd2, 17'd131071);
        set_cfg(11'd37, 11'd1024);
        send_item(8'd255, 18'd0, 2'd0, 17'd65536);
        send_item(8'd32, 18'd49153, 2'd0, 17'd16384);
        set_cfg(11'd61, 11'd16);
        send_item(8'd32, 18'd1024, 2'd3, 17'd100);
        set_cfg(11'd53, 11'd2047);
        send_item(8'd32, 18'd1024, 2'd0, 17'd65536);
        send_item(8'd1, 18'd0, 2'd1, 17'd0);
        set_cfg(11'd2047, 11'd1);
        send_item(8'd10, 18'd0, 2'd0, 17'd1);

        // Random phases, each under its own configuration
        for (int p = 0; p < 11; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80) a = 11'(known_codes[$urandom_range(0, 10)]);
            else if (r < 88) a = 0;
            else a = 11'($urandom_range(0, 2047));
            r = $urandom_range(0, 99);
            if (r < 75) t = 11'($urandom_range(1, 1024));
            else if (r < 85) t = 11'($urandom_range(1, 31));
            else if (r < 92) t = 0;
            else t = 11'($urandom_range(1025, 2047));
            set_cfg(a, t);
            no_gaps = (p % 4 == 1);
            repeat (150) rand_item();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            sb.report("request left without a result");
            void'(sb.pending.pop_front());
        end
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
